// ----- hw/rtl/svrp_pkg.sv -----
// ----------------------------------------------------------------------------
// svrp_pkg
// shared types, constants and the sine table for the stereo vertex pipeline
// ----------------------------------------------------------------------------
package svrp_pkg;

    localparam int TRIG_STEPS      = 512;
    localparam int TRIG_IDX_W      = $clog2(TRIG_STEPS);
    localparam int HALF_IDX_W      = TRIG_IDX_W - 1;
    localparam int TRIG_QUARTER    = TRIG_STEPS / 4;
    localparam int TRIG_HALF       = TRIG_STEPS / 2;
    localparam int QTAB_N          = TRIG_QUARTER + 1;
    localparam int TRIG_FRAC_BITS  = 14;
    localparam int TRIG_W          = 16;
    localparam int COORD_FRAC_BITS = 16;
    localparam int COORD_W         = 32;
    localparam int PIX_W           = 16;
    localparam int EYE_W           = 31;
    localparam int FOCAL_W         = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    // projection datapath widths
    localparam int DEPTH_W = COORD_W + 1;                 // rz + world_z
    localparam int PEYE_W  = COORD_W + 2;                 // rx + world_x - eye
    localparam int NUM_W   = PEYE_W + FOCAL_W + 1;        // p * focal, signed
    localparam int REM_W   = NUM_W - 1;                   // numerator magnitude

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // reset values
    localparam int ANGLE_X_RESET = 1;
    localparam int ANGLE_Y_RESET = 2;
    localparam int ANGLE_Z_RESET = 3;
    localparam logic signed [COORD_W-1:0] WORLD_Z_RESET = 32'sd32768000;
    localparam logic [EYE_W-1:0]          EYE_RESET     = 31'd655360;
    localparam logic [FOCAL_W-1:0]        FOCAL_RESET   = 16'd1024;

    typedef logic signed [TRIG_W-1:0]   trig_t;
    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [PIX_W-1:0]    screen_t;
    typedef logic [TRIG_IDX_W-1:0]      trig_idx_t;
    typedef logic [HALF_IDX_W-1:0]      half_idx_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORLD_X        = 3'd0,
        REG_WORLD_Y        = 3'd1,
        REG_WORLD_Z        = 3'd2,
        REG_ANGLE_X        = 3'd3,
        REG_ANGLE_Y        = 3'd4,
        REG_ANGLE_Z        = 3'd5,
        REG_EYE_SEPARATION = 3'd6,
        REG_FOCAL_SCALE    = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        coord_t vertex_x;
        coord_t vertex_y;
        coord_t vertex_z;
    } vertex_t;

    typedef struct packed {
        coord_t  rotated_x;
        coord_t  rotated_y;
        coord_t  rotated_z;
        screen_t left_screen_x;
        screen_t right_screen_x;
        screen_t screen_y;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_wr_t;

    typedef struct packed {
        coord_t             world_x;
        coord_t             world_y;
        coord_t             world_z;
        logic [EYE_W-1:0]   eye_separation;
        logic [FOCAL_W-1:0] focal_scale;
    } proj_cfg_t;

    typedef struct packed {
        trig_t sin;
        trig_t cos;
    } trig_pair_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } rot_vec_t;

    typedef trig_t qtab_t [QTAB_N];

    // round(16384 * sin(pi * k / half)) for k in the first quarter, taylor series in q30
    function automatic trig_t quarter_sine(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = (PI_Q30 * 64'd2 * 64'(k) + 64'(TRIG_HALF)) / TRIG_STEPS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int unsigned n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        r = (sum + 64'd32768) >> 16;
        if (r > 64'd16384)
            r = 64'd16384;
        return trig_t'(r[TRIG_W-1:0]);
    endfunction

    // first quarter of the wave, both ends included
    function automatic qtab_t build_quarter();
        qtab_t tab;
        for (int unsigned k = 0; k < QTAB_N; k++)
            tab[k] = quarter_sine(k);
        return tab;
    endfunction

    localparam qtab_t QUARTER_ROM = build_quarter();

    // full-turn sine folded onto the quarter table, negated in the second half
    function automatic trig_t trig_sin(input trig_idx_t a);
        half_idx_t j;
        half_idx_t k;
        trig_t     v;
        j = a[HALF_IDX_W-1:0];
        k = (j <= half_idx_t'(TRIG_QUARTER)) ? j : half_idx_t'(TRIG_HALF - int'(j));
        v = QUARTER_ROM[k];
        return a[TRIG_IDX_W-1] ? trig_t'(-v) : v;
    endfunction

    // sine and cosine of one angle step, cosine a quarter turn further on
    function automatic trig_pair_t trig_lookup(input trig_idx_t a);
        trig_pair_t p;
        p.sin = trig_sin(a);
        p.cos = trig_sin(trig_idx_t'(a + trig_idx_t'(TRIG_QUARTER)));
        return p;
    endfunction

endpackage

// ----- hw/rtl/svrp_stream_if.sv -----
// ----------------------------------------------------------------------------
// svrp_stream_if
// valid/ready channel with a typed payload
// ----------------------------------------------------------------------------
interface svrp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/svrp_cfg.sv -----
// ----------------------------------------------------------------------------
// svrp_cfg
// configuration registers, angles kept as sine/cosine pairs
// ----------------------------------------------------------------------------
module svrp_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  svrp_pkg::cfg_wr_t     wr,
    output svrp_pkg::proj_cfg_t   proj,
    output svrp_pkg::trig_pair_t  trig_x,
    output svrp_pkg::trig_pair_t  trig_y,
    output svrp_pkg::trig_pair_t  trig_z
);
    import svrp_pkg::*;

    proj_cfg_t  proj_reg;
    trig_pair_t trig_x_reg;
    trig_pair_t trig_y_reg;
    trig_pair_t trig_z_reg;
    trig_idx_t  wr_angle;

    assign wr_angle = wr.value[TRIG_IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            proj_reg.world_x        <= '0;
            proj_reg.world_y        <= '0;
            proj_reg.world_z        <= WORLD_Z_RESET;
            proj_reg.eye_separation <= EYE_RESET;
            proj_reg.focal_scale    <= FOCAL_RESET;
            trig_x_reg              <= trig_lookup(trig_idx_t'(ANGLE_X_RESET));
            trig_y_reg              <= trig_lookup(trig_idx_t'(ANGLE_Y_RESET));
            trig_z_reg              <= trig_lookup(trig_idx_t'(ANGLE_Z_RESET));
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_e'(wr.index))
                REG_WORLD_X:        proj_reg.world_x        <= $signed(wr.value);
                REG_WORLD_Y:        proj_reg.world_y        <= $signed(wr.value);
                REG_WORLD_Z:        proj_reg.world_z        <= $signed(wr.value);
                REG_ANGLE_X:        trig_x_reg              <= trig_lookup(wr_angle);
                REG_ANGLE_Y:        trig_y_reg              <= trig_lookup(wr_angle);
                REG_ANGLE_Z:        trig_z_reg              <= trig_lookup(wr_angle);
                REG_EYE_SEPARATION: proj_reg.eye_separation <= wr.value[EYE_W-1:0];
                REG_FOCAL_SCALE:    proj_reg.focal_scale    <= wr.value[FOCAL_W-1:0];
                default:            proj_reg                <= proj_reg;
            endcase
        end
    end

    assign proj   = proj_reg;
    assign trig_x = trig_x_reg;
    assign trig_y = trig_y_reg;
    assign trig_z = trig_z_reg;

    a_angle_x_sin: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && wr.index == REG_ANGLE_X |=>
            trig_x_reg.sin == trig_sin($past(wr_angle)))
        else $error("angle x write did not load its sine");

    a_angle_z_cos: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && wr.index == REG_ANGLE_Z |=>
            trig_z_reg.cos == trig_sin(trig_idx_t'($past(wr_angle) + trig_idx_t'(TRIG_QUARTER))))
        else $error("angle z write did not load its cosine");

endmodule

// ----- hw/rtl/svrp_rotate.sv -----
// ----------------------------------------------------------------------------
// svrp_rotate
// one plane rotation: products stage, then round, saturate stage
// ----------------------------------------------------------------------------
module svrp_rotate (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  svrp_pkg::coord_t     a,
    input  svrp_pkg::coord_t     b,
    input  svrp_pkg::coord_t     side,
    input  svrp_pkg::trig_pair_t trig,
    output logic                 out_valid,
    output svrp_pkg::coord_t     out_a,
    output svrp_pkg::coord_t     out_b,
    output svrp_pkg::coord_t     out_side
);
    import svrp_pkg::*;

    localparam int PROD_W = COORD_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int ROUND_HALF = 1 << (TRIG_FRAC_BITS - 1);

    logic signed [PROD_W-1:0] p_ac_reg;
    logic signed [PROD_W-1:0] p_bs_reg;
    logic signed [PROD_W-1:0] p_as_reg;
    logic signed [PROD_W-1:0] p_bc_reg;
    coord_t                   side_s1_reg;
    logic                     valid_s1_reg;

    coord_t out_a_reg;
    coord_t out_b_reg;
    coord_t side_s2_reg;
    logic   valid_s2_reg;

    coord_t out_a_next;
    coord_t out_b_next;

    function automatic coord_t round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] r;
        logic                    hi_ones;
        logic                    hi_any;
        r       = (s + SUM_W'(ROUND_HALF)) >>> TRIG_FRAC_BITS;
        hi_ones = &r[SUM_W-1:COORD_W-1];
        hi_any  = |r[SUM_W-1:COORD_W-1];
        if (hi_ones || !hi_any)
            return r[COORD_W-1:0];
        else if (r[SUM_W-1])
            return {1'b1, {(COORD_W-1){1'b0}}};
        else
            return {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_s1_reg <= in_valid;
            valid_s2_reg <= valid_s1_reg;
        end
    end

    always_comb begin
        out_a_next = round_sat(SUM_W'(p_ac_reg) - SUM_W'(p_bs_reg));
        out_b_next = round_sat(SUM_W'(p_as_reg) + SUM_W'(p_bc_reg));
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            p_ac_reg    <= a * trig.cos;
            p_bs_reg    <= b * trig.sin;
            p_as_reg    <= a * trig.sin;
            p_bc_reg    <= b * trig.cos;
            side_s1_reg <= side;
            out_a_reg   <= out_a_next;
            out_b_reg   <= out_b_next;
            side_s2_reg <= side_s1_reg;
        end
    end

    assign out_valid = valid_s2_reg;
    assign out_a     = out_a_reg;
    assign out_b     = out_b_reg;
    assign out_side  = side_s2_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(out_a_reg) && $stable(out_b_reg) && $stable(valid_s2_reg))
        else $error("rotation output moved during a stall");

    a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> valid_s2_reg == $past(valid_s1_reg))
        else $error("rotation valid lost or invented");

    a_ident_rot: assert property (@(posedge clk) disable iff (!rst_n)
        en && valid_s1_reg && p_bs_reg == '0 && p_as_reg == '0 && p_ac_reg == '0
            && p_bc_reg == '0 |=> out_a_reg == '0 && out_b_reg == '0)
        else $error("zero products did not give a zero rotation");

endmodule

// ----- hw/rtl/svrp_div.sv -----
// ----------------------------------------------------------------------------
// svrp_div
// pipelined restoring divide, one quotient bit per stage, saturated to 16 bits
// ----------------------------------------------------------------------------
module svrp_div (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [svrp_pkg::NUM_W-1:0]      num,
    input  logic [svrp_pkg::DEPTH_W-1:0]           d_mag,
    input  logic                                   d_neg,
    output svrp_pkg::screen_t                      quot
);
    import svrp_pkg::*;

    localparam int Q_W = PIX_W;

    logic [REM_W-1:0]   rem_reg [Q_W];
    logic [DEPTH_W-1:0] d_reg   [Q_W];
    logic [Q_W-1:0]     q_reg   [Q_W+1];
    logic               neg_reg [Q_W+1];
    logic               ovf_reg [Q_W+1];
    screen_t            quot_reg;

    logic [NUM_W-1:0] mag_full;
    logic [REM_W-1:0] mag;
    logic [REM_W-1:0] d_top;

    assign mag_full = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign mag      = mag_full[REM_W-1:0];
    assign d_top    = REM_W'({d_mag, {Q_W{1'b0}}});

    // entry stage: magnitude and overflow check against d << 16
    always_ff @(posedge clk) begin
        if (en)
        begin
            rem_reg[0] <= mag;
            d_reg[0]   <= d_mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NUM_W-1] ^ d_neg;
            ovf_reg[0] <= (mag >= d_top);
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [REM_W-1:0] trial;
        logic             take;

        assign trial = REM_W'(d_reg[k]) << (Q_W - 1 - k);
        assign take  = rem_reg[k] >= trial;

        always_ff @(posedge clk) begin
            if (en)
            begin
                q_reg[k+1]   <= {q_reg[k][Q_W-2:0], take};
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end

        if (k < Q_W - 1) begin : g_carry
            always_ff @(posedge clk) begin
                if (en)
                begin
                    rem_reg[k+1] <= take ? (rem_reg[k] - trial) : rem_reg[k];
                    d_reg[k+1]   <= d_reg[k];
                end
            end
        end
    end

    // truncate toward zero, saturate
    always_ff @(posedge clk) begin
        if (en)
        begin
            if (neg_reg[Q_W])
            begin
                if (ovf_reg[Q_W] || q_reg[Q_W] > {1'b1, {(Q_W-1){1'b0}}})
                    quot_reg <= {1'b1, {(Q_W-1){1'b0}}};
                else
                    quot_reg <= screen_t'(-q_reg[Q_W]);
            end
            else
            begin
                if (ovf_reg[Q_W] || q_reg[Q_W][Q_W-1])
                    quot_reg <= {1'b0, {(Q_W-1){1'b1}}};
                else
                    quot_reg <= screen_t'(q_reg[Q_W]);
            end
        end
    end

    assign quot = quot_reg;

endmodule

// ----- hw/rtl/svrp_project.sv -----
// ----------------------------------------------------------------------------
// svrp_project
// world offset, focal multiply and three divide lanes for the stereo screen
// ----------------------------------------------------------------------------
module svrp_project (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  svrp_pkg::rot_vec_t   rot,
    input  svrp_pkg::proj_cfg_t  cfg,
    output logic                 out_valid,
    output svrp_pkg::result_t    res
);
    import svrp_pkg::*;

    localparam int DIV_LAT = PIX_W + 2;
    localparam int LAT     = DIV_LAT + 2;

    logic               valid_reg [LAT];
    rot_vec_t           rot_reg   [LAT];

    logic signed [DEPTH_W-1:0] px_reg;
    logic signed [PEYE_W-1:0]  pe_reg;
    logic signed [DEPTH_W-1:0] py_reg;
    logic signed [DEPTH_W-1:0] d_reg;

    logic signed [NUM_W-1:0]   nl_reg;
    logic signed [NUM_W-1:0]   nr_reg;
    logic signed [NUM_W-1:0]   ny_reg;
    logic [DEPTH_W-1:0]        dmag_reg;
    logic                      dneg_reg;

    logic signed [DEPTH_W-1:0] d_next;
    logic signed [FOCAL_W:0]   focal_s;
    screen_t                   q_left;
    screen_t                   q_right;
    screen_t                   q_y;

    always_comb begin
        d_next = DEPTH_W'(rot.z) + DEPTH_W'(cfg.world_z);
        if (d_next == '0)
            d_next = DEPTH_W'(1 << COORD_FRAC_BITS);
    end

    assign focal_s = $signed({1'b0, cfg.focal_scale});

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            rot_reg[0] <= rot;
            for (int i = 1; i < LAT; i++)
                rot_reg[i] <= rot_reg[i-1];

            px_reg <= DEPTH_W'(rot.x) + DEPTH_W'(cfg.world_x);
            pe_reg <= PEYE_W'(rot.x) + PEYE_W'(cfg.world_x)
                      - $signed(PEYE_W'(cfg.eye_separation));
            py_reg <= DEPTH_W'(rot.y) + DEPTH_W'(cfg.world_y);
            d_reg  <= d_next;

            nl_reg   <= px_reg * focal_s;
            nr_reg   <= pe_reg * focal_s;
            ny_reg   <= py_reg * focal_s;
            dmag_reg <= d_reg[DEPTH_W-1] ? DEPTH_W'(-d_reg) : DEPTH_W'(d_reg);
            dneg_reg <= d_reg[DEPTH_W-1];
        end
    end

    svrp_div u_div_left (
        .clk   (clk),
        .en    (en),
        .num   (nl_reg),
        .d_mag (dmag_reg),
        .d_neg (dneg_reg),
        .quot  (q_left)
    );

    svrp_div u_div_right (
        .clk   (clk),
        .en    (en),
        .num   (nr_reg),
        .d_mag (dmag_reg),
        .d_neg (dneg_reg),
        .quot  (q_right)
    );

    svrp_div u_div_y (
        .clk   (clk),
        .en    (en),
        .num   (ny_reg),
        .d_mag (dmag_reg),
        .d_neg (dneg_reg),
        .quot  (q_y)
    );

    always_comb begin
        res.rotated_x      = rot_reg[LAT-1].x;
        res.rotated_y      = rot_reg[LAT-1].y;
        res.rotated_z      = rot_reg[LAT-1].z;
        res.left_screen_x  = q_left;
        res.right_screen_x = q_right;
        res.screen_y       = q_y;
    end

    assign out_valid = valid_reg[LAT-1];

    a_depth_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> dmag_reg != '0 || !$past(valid_reg[0]))
        else $error("divisor reached the divide lanes as zero");

    a_proj_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(out_valid) && $stable(res))
        else $error("projection output moved during a stall");

    a_valid_shift: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> valid_reg[LAT-1] == $past(valid_reg[LAT-2]))
        else $error("projection valid lost or invented");

endmodule

// ----- hw/rtl/stereo_vertex_rotate_project.sv -----
// ----------------------------------------------------------------------------
// stereo_vertex_rotate_project
// rotates a q16.16 vertex about x, y, z and projects it for two eyes
// ----------------------------------------------------------------------------
// pipeline: 3 x 2 rotation stages, 2 projection stages and 18 divide stages
//   (incl. entry and saturate) between vertex transfer and result valid
// throughput: one vertex per cycle; the whole pipeline advances together and
//   freezes while a finished result waits on the output register
// reset: clears all valid bits and loads the register defaults
//   (world 0/0/500.0, angles 1/2/3, eye 10.0, focal 1024); cfg always ready
// ----------------------------------------------------------------------------
module stereo_vertex_rotate_project (
    input  logic         clk,
    input  logic         rst_n,
    svrp_stream_if.sink   vertex,
    svrp_stream_if.source result,
    svrp_stream_if.sink   cfg
);
    import svrp_pkg::*;

    // pipeline advance: output register empty or being drained this cycle
    logic en;

    proj_cfg_t  proj_cfg;
    trig_pair_t trig_x;
    trig_pair_t trig_y;
    trig_pair_t trig_z;

    // rotation stage outputs
    logic     rx_valid;
    coord_t   rx_y;
    coord_t   rx_z;
    coord_t   rx_x;
    logic     ry_valid;
    coord_t   ry_x;
    coord_t   ry_z;
    coord_t   ry_y;
    logic     rz_valid;
    coord_t   rz_x;
    coord_t   rz_y;
    coord_t   rz_z;
    rot_vec_t rot_vec;

    logic    proj_valid;
    result_t proj_res;

    assign en           = !proj_valid || result.ready;
    assign vertex.ready = en;

    // configuration writes are taken in every cycle
    assign cfg.ready = 1'b1;

    svrp_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cfg.valid),
        .wr     (cfg.data),
        .proj   (proj_cfg),
        .trig_x (trig_x),
        .trig_y (trig_y),
        .trig_z (trig_z)
    );

    // about x: (y, z) -> (y*c - z*s, y*s + z*c)
    svrp_rotate u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vertex.valid),
        .a         (vertex.data.vertex_y),
        .b         (vertex.data.vertex_z),
        .side      (vertex.data.vertex_x),
        .trig      (trig_x),
        .out_valid (rx_valid),
        .out_a     (rx_y),
        .out_b     (rx_z),
        .out_side  (rx_x)
    );

    // about y, this sign convention: (x, z) -> (x*c - z*s, x*s + z*c)
    svrp_rotate u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rx_valid),
        .a         (rx_x),
        .b         (rx_z),
        .side      (rx_y),
        .trig      (trig_y),
        .out_valid (ry_valid),
        .out_a     (ry_x),
        .out_b     (ry_z),
        .out_side  (ry_y)
    );

    // about z: (x, y) -> (x*c - y*s, x*s + y*c)
    svrp_rotate u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ry_valid),
        .a         (ry_x),
        .b         (ry_y),
        .side      (ry_z),
        .trig      (trig_z),
        .out_valid (rz_valid),
        .out_a     (rz_x),
        .out_b     (rz_y),
        .out_side  (rz_z)
    );

    always_comb begin
        rot_vec.x = rz_x;
        rot_vec.y = rz_y;
        rot_vec.z = rz_z;
    end

    // offset, focal scale and perspective divide; last stage is the output register
    svrp_project u_project (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rz_valid),
        .rot       (rot_vec),
        .cfg       (proj_cfg),
        .out_valid (proj_valid),
        .res       (proj_res)
    );

    assign result.valid = proj_valid;
    assign result.data  = proj_res;

    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !vertex.ready)
        else $error("vertex taken while the result is stalled");

    a_drain_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        result.ready |-> vertex.ready)
        else $error("input blocked although the output drains");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        proj_valid && !result.ready |=> proj_valid && $stable(proj_res))
        else $error("stalled result changed");

endmodule
